@@ src/bocc_pkg.sv @@
// Shared types, constants and helpers of the box occlusion depth buffer.
`timescale 1ns / 1ps
package bocc_pkg;

	localparam int DEF_SCREEN_WIDTH  = 128;
	localparam int DEF_SCREEN_HEIGHT = 64;

	// Screen coordinates never exceed 1023 for the allowed screen sizes.
	localparam int COORD_W     = 10;
	localparam int QUEUE_DEPTH = 2;
	localparam int NUM_REGS    = 8;

	localparam logic signed [31:0] DEPTH_ONE = 32'sd65536;
	localparam logic signed [63:0] W_EPS     = 64'sd429497;
	localparam logic [31:0]        QUOT_MAX  = 32'h7FFF_FFFF;

	localparam logic [63:0] MAT_RESET [NUM_REGS] = '{
		64'd16777216, 64'd0, 64'd72057594037927936, 64'd0,
		64'd0, 64'd16777216, 64'd0, 64'd72057594037927936
	};

	function automatic int clog2m1(input int n);
		int r;
		begin
			r = $clog2(n);
			return (r < 1) ? 1 : r;
		end
	endfunction

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_ADD   = 2'd1,
		FUNC_TEST  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_e;

	typedef enum logic [1:0] {
		OP_CLEAR,
		OP_ADD,
		OP_TEST,
		OP_NONE
	} op_e;

	typedef struct packed {
		func_e              func;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_min_z;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
		logic signed [31:0] box_max_z;
	} req_t;

	typedef struct packed {
		logic occluded;
		logic rect_nonempty;
	} rsp_t;

	// Work handed from the projection front end to the raster back end.
	typedef struct packed {
		op_e                op;
		logic               ok;
		logic [COORD_W-1:0] x0;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic signed [31:0] near_d;
		logic signed [31:0] far_d;
	} cmd_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_INIT,
		F_MUL,
		F_ACC,
		F_WCHK,
		F_DINIT,
		F_DSTEP,
		F_DFIN,
		F_FINAL,
		F_PUSH
	} fstate_e;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_START,
		B_WALK,
		B_DRAIN,
		B_DONE
	} bstate_e;

endpackage

@@ src/bocc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bocc_ram #(
	parameter int DATA_W = 32,
	parameter int DEPTH  = 8192
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [bocc_pkg::clog2m1(DEPTH)-1:0]  waddr,
	input  logic [DATA_W-1:0]                    wdata,
	input  logic [bocc_pkg::clog2m1(DEPTH)-1:0]  raddr,
	output logic [DATA_W-1:0]                    rdata
);
	import bocc_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/bocc_queue.sv @@
// Short command queue between the projection front end and the raster back end.
`timescale 1ns / 1ps
module bocc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bocc_pkg::cmd_t  push_data,
	output logic            full,
	input  logic            pop,
	output bocc_pkg::cmd_t  pop_data,
	output logic            empty
);
	import bocc_pkg::*;

	localparam int PW = clog2m1(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/bocc_front.sv @@
// Front end: accepts items, projects the box corners and builds raster commands.
`timescale 1ns / 1ps
module bocc_front #(
	parameter int SCREEN_WIDTH  = bocc_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = bocc_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  bocc_pkg::req_t       req,
	input  logic [7:0][63:0]     matrix,
	output logic                 push,
	output bocc_pkg::cmd_t       cmd,
	input  logic                 full
);
	import bocc_pkg::*;

	fstate_e state_q, state_d;

	req_t               item_q;
	logic [2:0]         corner_q;
	logic [1:0]         row_q;
	logic [1:0]         col_q;
	logic [1:0]         j_q;
	logic signed [63:0] prod_q;
	logic signed [63:0] clip_q [4];
	logic [63:0]        d_q;
	logic [63:0]        rem_q;
	logic [14:0]        sh_q;
	logic [30:0]        quo_q;
	logic [4:0]         cnt_q;
	logic               sat_q;
	logic               neg_q;
	logic signed [44:0] left_q, right_q, top_q, bottom_q;
	logic signed [31:0] nd_q, fd_q;
	cmd_t               cmd_q;

	op_e                req_op;
	logic [3:0]         ent_idx;
	logic signed [31:0] ent;
	logic signed [31:0] pval;
	logic signed [63:0] num;
	logic [63:0]        absnum;
	logic [64:0]        trial;
	logic [31:0]        qmag;
	logic signed [31:0] qs;
	logic signed [32:0] qe;
	logic signed [44:0] scaled;
	logic signed [44:0] lx, rx, ty, by;
	logic signed [44:0] x0c, x1c, y0c, y1c;

	assign busy = (state_q != F_IDLE);
	assign push = (state_q == F_PUSH) && !full;
	assign cmd  = cmd_q;

	always_comb begin
		case (req.func)
			FUNC_CLEAR: req_op = OP_CLEAR;
			FUNC_ADD:   req_op = OP_ADD;
			FUNC_TEST:  req_op = OP_TEST;
			default:    req_op = OP_NONE;
		endcase
	end

	// Column-major entry: column col_q, row row_q.
	assign ent_idx = {col_q, row_q};
	assign ent     = $signed(matrix[ent_idx[3:1]][ent_idx[0]*32 +: 32]);

	always_comb begin
		case (col_q)
			2'd0:    pval = corner_q[0] ? item_q.box_max_x : item_q.box_min_x;
			2'd1:    pval = corner_q[1] ? item_q.box_max_y : item_q.box_min_y;
			default: pval = corner_q[2] ? item_q.box_max_z : item_q.box_min_z;
		endcase
	end

	assign num    = clip_q[j_q];
	assign absnum = num[63] ? (~num + 64'd1) : num;
	assign trial  = {rem_q, sh_q[14]};
	assign qmag   = sat_q ? QUOT_MAX : {1'b0, quo_q};
	assign qs     = neg_q ? -$signed(qmag) : $signed(qmag);
	assign qe     = {qs[31], qs} + 33'sd65536;
	assign scaled = 45'(qe) * $signed(45'((j_q == 2'd0) ? SCREEN_WIDTH : SCREEN_HEIGHT));

	// Floor for the low edges and ceiling for the high edges, then clamp.
	assign lx  = left_q >>> 17;
	assign ty  = top_q >>> 17;
	assign rx  = (right_q + 45'sd131071) >>> 17;
	assign by  = (bottom_q + 45'sd131071) >>> 17;
	assign x0c = (lx < 0) ? '0 : lx;
	assign y0c = (ty < 0) ? '0 : ty;
	assign x1c = (rx > 45'(SCREEN_WIDTH - 1)) ? 45'(SCREEN_WIDTH - 1) : rx;
	assign y1c = (by > 45'(SCREEN_HEIGHT - 1)) ? 45'(SCREEN_HEIGHT - 1) : by;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (start) begin
					if (req.func == FUNC_ADD || req.func == FUNC_TEST) begin
						state_d = F_INIT;
					end else begin
						state_d = F_PUSH;
					end
				end
			end
			F_INIT: state_d = F_MUL;
			F_MUL:  state_d = F_ACC;
			F_ACC: begin
				if (col_q == 2'd2 && row_q == 2'd3) begin
					state_d = F_WCHK;
				end else begin
					state_d = F_MUL;
				end
			end
			F_WCHK:  state_d = (clip_q[3] <= W_EPS) ? F_PUSH : F_DINIT;
			F_DINIT: state_d = F_DSTEP;
			F_DSTEP: state_d = (cnt_q == 5'd30) ? F_DFIN : F_DSTEP;
			F_DFIN: begin
				if (j_q != 2'd2) begin
					state_d = F_DINIT;
				end else if (corner_q == 3'd7) begin
					state_d = F_FINAL;
				end else begin
					state_d = F_INIT;
				end
			end
			F_FINAL: state_d = F_PUSH;
			F_PUSH:  state_d = full ? F_PUSH : F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				item_q   <= req;
				corner_q <= '0;
				cmd_q    <= cmd_t'({req_op, ($bits(cmd_t) - $bits(op_e))'(0)});
			end
			F_INIT: begin
				// The translation column seeds each row, scaled to the Q.32 grid.
				for (int r = 0; r < 4; r++) begin
					clip_q[r] <= 64'($signed(matrix[6 + r/2][(r%2)*32 +: 32])) <<< 8;
				end
				row_q <= '0;
				col_q <= '0;
			end
			F_MUL: prod_q <= ent * pval;
			F_ACC: begin
				clip_q[row_q] <= clip_q[row_q] + (prod_q >>> 8);
				if (col_q == 2'd2) begin
					col_q <= '0;
					row_q <= row_q + 2'd1;
				end else begin
					col_q <= col_q + 2'd1;
				end
				j_q <= '0;
			end
			F_DINIT: begin
				neg_q <= num[63];
				d_q   <= clip_q[3];
				sat_q <= ({15'd0, absnum} >= {clip_q[3], 15'd0});
				rem_q <= absnum >> 15;
				sh_q  <= absnum[14:0];
				quo_q <= '0;
				cnt_q <= '0;
			end
			F_DSTEP: begin
				if (trial >= {1'b0, d_q}) begin
					rem_q <= 64'(trial - {1'b0, d_q});
					quo_q <= {quo_q[29:0], 1'b1};
				end else begin
					rem_q <= trial[63:0];
					quo_q <= {quo_q[29:0], 1'b0};
				end
				sh_q  <= {sh_q[13:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
			end
			F_DFIN: begin
				case (j_q)
					2'd0: begin
						if (corner_q == 3'd0 || scaled < left_q) left_q <= scaled;
						if (corner_q == 3'd0 || scaled > right_q) right_q <= scaled;
					end
					2'd1: begin
						if (corner_q == 3'd0 || scaled < top_q) top_q <= scaled;
						if (corner_q == 3'd0 || scaled > bottom_q) bottom_q <= scaled;
					end
					default: begin
						if (corner_q == 3'd0 || qs < nd_q) nd_q <= qs;
						if (corner_q == 3'd0 || qs > fd_q) fd_q <= qs;
					end
				endcase
				if (j_q == 2'd2) begin
					corner_q <= corner_q + 3'd1;
				end
				j_q <= j_q + 2'd1;
			end
			F_FINAL: begin
				cmd_q.ok     <= (x0c <= x1c) && (y0c <= y1c);
				cmd_q.x0     <= x0c[COORD_W-1:0];
				cmd_q.y0     <= y0c[COORD_W-1:0];
				cmd_q.x1     <= x1c[COORD_W-1:0];
				cmd_q.y1     <= y1c[COORD_W-1:0];
				cmd_q.near_d <= nd_q;
				cmd_q.far_d  <= fd_q;
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

endmodule

@@ src/bocc_back.sv @@
// Back end: clears the depth store and walks rectangles for adds and tests.
`timescale 1ns / 1ps
module bocc_back #(
	parameter int SCREEN_WIDTH  = bocc_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = bocc_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  bocc_pkg::cmd_t  cmd,
	output logic            pop,
	output logic            done,
	output bocc_pkg::rsp_t  rsp
);
	import bocc_pkg::*;

	localparam int NPIX = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int AW   = clog2m1(NPIX);

	bstate_e state_q, state_d;

	cmd_t               cmd_q;
	logic [AW-1:0]      clr_addr_q;
	logic               clr_item_q;
	logic [AW-1:0]      row_base_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic               v_s1;
	logic [AW-1:0]      addr_s1;
	logic               hidden_q;
	logic               done_q;
	rsp_t               rsp_q;

	logic               we;
	logic [AW-1:0]      waddr;
	logic [31:0]        wdata;
	logic [AW-1:0]      raddr;
	logic [31:0]        rdata;
	logic               deeper;

	assign done = done_q;
	assign rsp  = rsp_q;
	assign pop  = (state_q == B_IDLE) && !empty;

	assign raddr  = AW'(row_base_q + AW'(x_q));
	assign deeper = $signed(rdata) > ((cmd_q.op == OP_ADD) ? cmd_q.far_d : cmd_q.near_d);

	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = cmd_q.far_d;
		if (state_q == B_CLEAR) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = DEPTH_ONE;
		end else if (v_s1 && cmd_q.op == OP_ADD && deeper) begin
			we = 1'b1;
		end
	end

	bocc_ram #(
		.DATA_W (32),
		.DEPTH  (NPIX)
	) u_depth (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_CLEAR;
			clr_addr_q <= '0;
			clr_item_q <= 1'b0;
			v_s1       <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= (state_q == B_WALK);
			done_q  <= (state_q == B_DONE);
			if (state_q == B_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end else begin
				clr_addr_q <= '0;
			end
			if (pop) begin
				clr_item_q <= (cmd.op == OP_CLEAR);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_CLEAR: begin
				if (clr_addr_q == AW'(NPIX - 1)) begin
					state_d = clr_item_q ? B_DONE : B_IDLE;
				end
			end
			B_IDLE: begin
				if (!empty) begin
					if (cmd.op == OP_CLEAR) begin
						state_d = B_CLEAR;
					end else if (cmd.op == OP_NONE || !cmd.ok) begin
						state_d = B_DONE;
					end else begin
						state_d = B_START;
					end
				end
			end
			B_START: state_d = B_WALK;
			B_WALK: begin
				if (x_q == cmd_q.x1 && y_q == cmd_q.y1) begin
					state_d = B_DRAIN;
				end
			end
			B_DRAIN: state_d = B_DONE;
			B_DONE:  state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		addr_s1 <= raddr;
		if (pop) begin
			cmd_q <= cmd;
		end
		case (state_q)
			B_START: begin
				row_base_q <= AW'(cmd_q.y0 * (AW + COORD_W)'(SCREEN_WIDTH));
				x_q        <= cmd_q.x0;
				y_q        <= cmd_q.y0;
				hidden_q   <= 1'b1;
			end
			B_WALK: begin
				if (x_q == cmd_q.x1) begin
					x_q        <= cmd_q.x0;
					y_q        <= y_q + 1'b1;
					row_base_q <= row_base_q + AW'(SCREEN_WIDTH);
				end else begin
					x_q <= x_q + 1'b1;
				end
			end
			B_DONE: begin
				rsp_q.occluded      <= clr_item_q ? 1'b0 :
					(cmd_q.op == OP_TEST) && cmd_q.ok && hidden_q;
				rsp_q.rect_nonempty <= !clr_item_q && cmd_q.ok &&
					(cmd_q.op == OP_ADD || cmd_q.op == OP_TEST);
			end
			default: begin
				x_q <= x_q;
			end
		endcase
		// A test fails as soon as one pixel lies behind the near depth.
		if (v_s1 && cmd_q.op == OP_TEST && deeper) begin
			hidden_q <= 1'b0;
		end
	end

endmodule

@@ src/box_occlusion_depth_buffer.sv @@
// Top level of the box occlusion depth buffer: registers, front end, queue, back end.
// Usage: drive req and raise start; an item is taken at a clock edge where start is
// high and busy is low. Each item (clear, add occluder, test, no-op) produces exactly one
// result on rsp, marked by done for a single cycle; the receiver cannot stall it.
// Matrix registers are written through cfg_we, cfg_idx and cfg_wdata while idle;
// indexes beyond seven are ignored.
// Timing: the front end projects the eight corners one after another on one shared
// 32x32 multiplier and one bit-serial divider; an add or test ends early as soon as a
// corner falls behind the camera plane. The back end walks the rectangle at one pixel
// per cycle through the depth RAM; a clear sweeps all SCREEN_WIDTH*SCREEN_HEIGHT
// entries, one per cycle. A two-entry queue lets the front end start the next item
// while the back end is still rastering.
// Reset: registers return to the identity matrix, and the back end runs a clearing
// pass over all SCREEN_WIDTH*SCREEN_HEIGHT entries (8192 by default) before it
// executes queued work; items are still accepted during that pass.
`timescale 1ns / 1ps
module box_occlusion_depth_buffer #(
	parameter int SCREEN_WIDTH  = bocc_pkg::DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = bocc_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  bocc_pkg::req_t  req,
	output logic            done,
	output bocc_pkg::rsp_t  rsp,
	input  logic            cfg_we,
	input  logic [3:0]      cfg_idx,
	input  logic [63:0]     cfg_wdata
);
	import bocc_pkg::*;

	logic [7:0][63:0] mat_q;
	logic             push, full, pop, empty;
	cmd_t             push_cmd, pop_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				mat_q[i] <= MAT_RESET[i];
			end
		end else if (cfg_we && !cfg_idx[3]) begin
			mat_q[cfg_idx[2:0]] <= cfg_wdata;
		end
	end

	bocc_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.matrix (mat_q),
		.push   (push),
		.cmd    (push_cmd),
		.full   (full)
	);

	bocc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_cmd),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_cmd),
		.empty     (empty)
	);

	bocc_back #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.cmd    (pop_cmd),
		.pop    (pop),
		.done   (done),
		.rsp    (rsp)
	);

endmodule
